@@ rtl/balsm_pkg.sv @@
package balsm_pkg;

	localparam int MEM_BYTES_DEF = 65536;
	localparam int ADDR_IN_W = 16;
	localparam int DATA_W = 32;
	localparam int MODE_W = 3;

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_LB = 3'd0;
	localparam mode_t MODE_LBU = 3'd1;
	localparam mode_t MODE_LH = 3'd2;
	localparam mode_t MODE_LHU = 3'd3;
	localparam mode_t MODE_LW = 3'd4;
	localparam mode_t MODE_SB = 3'd5;
	localparam mode_t MODE_SH = 3'd6;
	localparam mode_t MODE_SW = 3'd7;

	// compare-subtract steps needed to fold a 16-bit address below m
	function automatic int red_steps(input longint m);
		int n;
		n = 0;
		for (int k = 0; k < 32; k++) begin
			if ((m << k) <= longint'((1 << ADDR_IN_W) - 1))
				n++;
		end
		return n;
	endfunction

	function automatic logic [ADDR_IN_W-1:0] mod_top(input longint m);
		int n;
		longint v;
		n = red_steps(m);
		v = (n > 0) ? (m << (n - 1)) : 0;
		return v[ADDR_IN_W-1:0];
	endfunction

	function automatic logic [1:0] last_byte(input mode_t mode);
		logic [1:0] r;
		case (mode)
			MODE_LB, MODE_LBU, MODE_SB: r = 2'd0;
			MODE_LH, MODE_LHU, MODE_SH: r = 2'd1;
			default: r = 2'd3;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/byte_addressed_load_store_memory.sv @@
// Byte-serial data memory: one memory byte is read or written per cycle.
// A request passes ST_REDUCE for the R address fold steps (0 when MEM_BYTES >= 65536),
// then ST_ACCESS for N = 1, 2 or 4 bytes, then ST_FIN and ST_DONE, which registers the
// result. Only one request is in flight: the next is taken only back in ST_IDLE.
// Reset: a clearing pass writes zero to all MEM_BYTES entries, one per cycle,
// with s_tready low until the pass finishes.
module byte_addressed_load_store_memory
	import balsm_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [15:0] byte_address, [47:16] store_value
	input  logic [2:0]  s_tuser,  // [2:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [31:0] load_value
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam int RED_N = red_steps(longint'(MEM_BYTES));
	localparam logic [ADDR_IN_W-1:0] MOD_TOP = mod_top(longint'(MEM_BYTES));
	localparam logic [ADDR_IN_W-1:0] MOD_LOW = ADDR_IN_W'(MEM_BYTES);
	localparam logic [AW-1:0] PTR_LAST = AW'(MEM_BYTES - 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_REDUCE = 3'd2;
	localparam logic [2:0] ST_ACCESS = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [7:0] mem [MEM_BYTES];

	logic [2:0]           state_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        ptr_q;
	logic [ADDR_IN_W-1:0] red_q;
	logic [ADDR_IN_W-1:0] mod_q;
	mode_t                mode_q;
	logic [DATA_W-1:0]    data_q;
	logic [1:0]           cnt_q;
	logic [1:0]           last_q;
	logic [DATA_W-1:0]    acc_q;
	logic [7:0]           rd_s1;
	logic                 rdv_s1;
	logic [1:0]           cnt_s1;
	logic                 m_tvalid_q;
	logic [DATA_W-1:0]    m_tdata_q;

	logic                 accept;
	logic                 is_store;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [7:0]           mem_wdata;
	logic [ADDR_IN_W-1:0] red_nx;
	logic [AW-1:0]        ptr_inc;
	logic [DATA_W-1:0]    result;
	logic                 out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign red_nx   = (red_q >= mod_q) ? red_q - mod_q : red_q;
	assign ptr_inc  = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;

	always_comb begin
		is_store = mode_q inside {MODE_SB, MODE_SH, MODE_SW};
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = data_q[8*cnt_q +: 8];
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_ACCESS && is_store) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		case (mode_q)
			MODE_LB:  result = {{24{acc_q[7]}}, acc_q[7:0]};
			MODE_LBU: result = {24'd0, acc_q[7:0]};
			MODE_LH:  result = {{16{acc_q[15]}}, acc_q[15:0]};
			MODE_LHU: result = {16'd0, acc_q[15:0]};
			MODE_LW:  result = acc_q;
			default:  result = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_s1 <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			rdv_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == ST_ACCESS) && !is_store;
			if (state_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PTR_LAST)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept)
						state_q <= (RED_N > 0) ? ST_REDUCE : ST_ACCESS;
				end
				ST_REDUCE: begin
					if (mod_q == MOD_LOW)
						state_q <= ST_ACCESS;
				end
				ST_ACCESS: begin
					if (cnt_q == last_q)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1 <= cnt_q;
		if (rdv_s1)
			acc_q[8*cnt_s1 +: 8] <= rd_s1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q <= mode_t'(s_tuser);
					data_q <= s_tdata[47:16];
					red_q  <= s_tdata[15:0];
					mod_q  <= MOD_TOP;
					ptr_q  <= AW'(s_tdata[15:0]);
					cnt_q  <= '0;
					last_q <= last_byte(mode_t'(s_tuser));
					acc_q  <= '0;
				end
			end
			ST_REDUCE: begin
				red_q <= red_nx;
				mod_q <= mod_q >> 1;
				if (mod_q == MOD_LOW)
					ptr_q <= AW'(red_nx);
			end
			ST_ACCESS: begin
				ptr_q <= ptr_inc;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_DONE: begin
				if (out_free)
					m_tdata_q <= result;
			end
			default: begin
			end
		endcase
	end

endmodule
